>>> rtl/motion_gesture_sequence_checker_assert.svh
// Assertion macros used by the motion gesture checker file.
`ifndef MOTION_GESTURE_SEQUENCE_CHECKER_ASSERT_SVH
`define MOTION_GESTURE_SEQUENCE_CHECKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MGSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MGSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mgsc_pkg.sv
// Types, codes and constants of the motion gesture sequence checker.
`default_nettype none

package mgsc_pkg;

    // One motion sample request.
    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] gyro_z;
        logic [31:0]        time_ms;
    } t_in_req;

    // One result request.
    typedef struct packed {
        logic [2:0] event_res;
        logic [1:0] step_after;
    } t_out_rsp;

    // Event codes reported per sample.
    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_STEP1   = 3'd1,
        EV_STEP2   = 3'd2,
        EV_SUCCESS = 3'd3,
        EV_FAIL    = 3'd4
    } t_event;

    // Sequence step awaited.
    typedef enum logic [1:0] {
        STEP_VERT   = 2'd0,
        STEP_HORIZ  = 2'd1,
        STEP_CIRCLE = 2'd2
    } t_step;

    // Configuration register indexes.
    localparam logic [2:0] REG_VERT_THR     = 3'd0;
    localparam logic [2:0] REG_HORIZ_THR    = 3'd1;
    localparam logic [2:0] REG_CIRC_THR     = 3'd2;
    localparam logic [2:0] REG_VERT_GOAL    = 3'd3;
    localparam logic [2:0] REG_HORIZ_GOAL   = 3'd4;
    localparam logic [2:0] REG_CIRC_GOAL    = 3'd5;
    localparam logic [2:0] REG_IDLE_TIMEOUT = 3'd6;
    localparam logic [2:0] REG_SHAKE_GAP    = 3'd7;

    // Register reset values.
    localparam logic [15:0] RST_VERT_THR     = 16'd32000;
    localparam logic [15:0] RST_HORIZ_THR    = 16'd32000;
    localparam logic [30:0] RST_CIRC_THR     = 31'd20000;
    localparam logic [3:0]  RST_GOAL         = 4'd5;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd1000;
    localparam logic [15:0] RST_SHAKE_GAP    = 16'd100;

    // The circle detector needs more than this many ms between counts.
    localparam logic [31:0] CIRCLE_GAP_MS = 32'd500;

endpackage

`default_nettype wire

>>> rtl/motion_gesture_sequence_checker.sv
// Top level of the motion gesture sequence checker.
//
//  Channel   Signals                               Direction  Moves
//  in        i_in_valid / o_in_ready / i_in_req    sink       one motion sample
//  out       o_out_valid / i_out_ready / o_out_rsp source     one event and step
//  cfg       i_cfg_valid / o_cfg_ready / index,data sink      one register write
//
// One sample per cycle is sustained while the result is not stalled: an input register
// feeds compare, add and count logic, whose result lands in the output register.
// A result moves from the input register into the output register when the output can load.
// Reset is synchronous and active low; it restores the register defaults.
// A stalled result holds in the output register while one more sample waits
// in the input register; configuration writes are never stalled.
`default_nettype none

module motion_gesture_sequence_checker
    import mgsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_req    i_in_req,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_rsp        o_out_rsp,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    // Configuration registers.
    logic [15:0] r_vert_thr;
    logic [15:0] r_horiz_thr;
    logic [30:0] r_circ_thr;
    logic [3:0]  r_vert_goal;
    logic [3:0]  r_horiz_goal;
    logic [3:0]  r_circ_goal;
    logic [15:0] r_idle_timeout;
    logic [15:0] r_shake_gap;

    // Pipeline registers.
    logic     r_in_valid;
    t_in_req  r_in;
    logic     r_out_valid;
    t_out_rsp r_out;

    // Detector state.
    t_step              r_step;
    logic [3:0]         r_vert_cnt;
    logic [3:0]         r_horiz_cnt;
    logic [3:0]         r_circ_cnt;
    logic [31:0]        r_vert_last;
    logic [31:0]        r_horiz_last;
    logic [31:0]        r_circ_last;
    logic signed [31:0] r_gyro_sum;

    // Next state.
    t_step              n_step;
    t_event             n_event;
    logic [3:0]         n_vert_cnt;
    logic [3:0]         n_horiz_cnt;
    logic [3:0]         n_circ_cnt;
    logic [31:0]        n_vert_last;
    logic [31:0]        n_horiz_last;
    logic [31:0]        n_circ_last;
    logic signed [31:0] n_gyro_sum;

    // Handshake control.
    logic w_out_load;
    logic w_advance;

    // Per-detector results, as if the detector were evaluated.
    logic [16:0] w_ax, w_ay, w_az;
    logic [31:0] w_v_el, w_h_el, w_c_el;
    logic [3:0]  w_v_cnt0, w_v_cnt1, w_v_cnt;
    logic [3:0]  w_h_cnt0, w_h_cnt1, w_h_cnt;
    logic [3:0]  w_c_cnt0, w_c_cnt1, w_c_cnt;
    logic        w_v_hit, w_v_fin;
    logic        w_h_hit, w_h_fin;
    logic        w_c_to, w_c_below, w_c_gap_ok, w_c_fin;
    logic [31:0] w_v_last, w_h_last, w_c_last;
    logic signed [31:0] w_c_sum0, w_c_sat, w_c_sum;
    logic [32:0] w_c_wide;
    logic [33:0] w_c_cmp;

    // Sequencer selection.
    logic w_eval_v, w_eval_h, w_eval_c, w_fail;

    // Magnitude of a signed 16-bit sample; -32768 gives 32768.
    function automatic logic [16:0] mag16(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? (~ext + 17'd1) : ext;
    endfunction

    // Handshake: the input stage moves on when the output stage can load.
    assign w_out_load  = !r_out_valid || i_out_ready;
    assign w_advance   = r_in_valid && w_out_load;
    assign o_in_ready  = !r_in_valid || w_out_load;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_ax = mag16(r_in.accel_x);
    assign w_ay = mag16(r_in.accel_y);
    assign w_az = mag16(r_in.accel_z);

    // Vertical detector.
    always_comb begin
        w_v_el   = r_in.time_ms - r_vert_last;
        w_v_cnt0 = (w_v_el > {16'd0, r_idle_timeout}) ? 4'd0 : r_vert_cnt;
        w_v_hit  = (w_az > {1'b0, r_vert_thr}) && (w_v_el > {16'd0, r_shake_gap});
        w_v_cnt1 = w_v_cnt0 + 4'd1;
        w_v_fin  = w_v_hit && (w_v_cnt1 == r_vert_goal);
        w_v_cnt  = w_v_hit ? (w_v_fin ? 4'd0 : w_v_cnt1) : w_v_cnt0;
        w_v_last = w_v_hit ? r_in.time_ms : r_vert_last;
    end

    // Horizontal detector.
    always_comb begin
        w_h_el   = r_in.time_ms - r_horiz_last;
        w_h_cnt0 = (w_h_el > {16'd0, r_idle_timeout}) ? 4'd0 : r_horiz_cnt;
        w_h_hit  = ((w_ax > {1'b0, r_horiz_thr}) || (w_ay > {1'b0, r_horiz_thr}))
                   && (w_h_el > {16'd0, r_shake_gap});
        w_h_cnt1 = w_h_cnt0 + 4'd1;
        w_h_fin  = w_h_hit && (w_h_cnt1 == r_horiz_goal);
        w_h_cnt  = w_h_hit ? (w_h_fin ? 4'd0 : w_h_cnt1) : w_h_cnt0;
        w_h_last = w_h_hit ? r_in.time_ms : r_horiz_last;
    end

    // Circle detector: saturating gyro sum against the negative threshold.
    always_comb begin
        w_c_el     = r_in.time_ms - r_circ_last;
        w_c_to     = w_c_el > {16'd0, r_idle_timeout};
        w_c_cnt0   = w_c_to ? 4'd0 : r_circ_cnt;
        w_c_sum0   = w_c_to ? 32'sd0 : r_gyro_sum;
        w_c_wide   = {w_c_sum0[31], w_c_sum0} + {{17{r_in.gyro_z[15]}}, r_in.gyro_z};
        if (w_c_wide[32] != w_c_wide[31]) begin
            w_c_sat = w_c_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            w_c_sat = w_c_wide[31:0];
        end
        // Sum plus threshold below zero means the sum is below -threshold.
        w_c_cmp    = {{2{w_c_sat[31]}}, w_c_sat} + {3'b000, r_circ_thr};
        w_c_below  = w_c_cmp[33];
        w_c_gap_ok = w_c_el > CIRCLE_GAP_MS;
        w_c_cnt1   = w_c_cnt0 + 4'd1;
        w_c_fin    = 1'b0;
        w_c_cnt    = w_c_cnt0;
        w_c_last   = r_circ_last;
        w_c_sum    = w_c_sat;
        if (w_c_below) begin
            if (w_c_gap_ok) begin
                w_c_fin  = (w_c_cnt1 == r_circ_goal);
                w_c_cnt  = w_c_fin ? 4'd0 : w_c_cnt1;
                w_c_last = r_in.time_ms;
                w_c_sum  = 32'sd0;
            end
        end else if (!w_c_sat[31] && (w_c_sat != 32'sd0)) begin
            w_c_sum = 32'sd0;
        end
    end

    // Sequencer: awaited detector first, stop at the first one that finishes.
    always_comb begin
        n_step   = r_step;
        n_event  = EV_NONE;
        w_eval_v = 1'b0;
        w_eval_h = 1'b0;
        w_eval_c = 1'b0;
        w_fail   = 1'b0;
        case (r_step)
            STEP_VERT: begin
                w_eval_v = 1'b1;
                if (w_v_fin) begin
                    n_step  = STEP_HORIZ;
                    n_event = EV_STEP1;
                end else begin
                    w_eval_h = 1'b1;
                    if (w_h_fin) begin
                        w_fail = 1'b1;
                    end else begin
                        w_eval_c = 1'b1;
                        w_fail   = w_c_fin;
                    end
                end
            end
            STEP_HORIZ: begin
                w_eval_h = 1'b1;
                if (w_h_fin) begin
                    n_step  = STEP_CIRCLE;
                    n_event = EV_STEP2;
                end else begin
                    w_eval_v = 1'b1;
                    if (w_v_fin) begin
                        w_fail = 1'b1;
                    end else begin
                        w_eval_c = 1'b1;
                        w_fail   = w_c_fin;
                    end
                end
            end
            STEP_CIRCLE: begin
                w_eval_c = 1'b1;
                if (w_c_fin) begin
                    n_step  = STEP_VERT;
                    n_event = EV_SUCCESS;
                end else begin
                    w_eval_v = 1'b1;
                    if (w_v_fin) begin
                        w_fail = 1'b1;
                    end else begin
                        w_eval_h = 1'b1;
                        w_fail   = w_h_fin;
                    end
                end
            end
            default: begin
            end
        endcase
        if (w_fail) begin
            n_step  = STEP_VERT;
            n_event = EV_FAIL;
        end
    end

    // Commit the evaluated detectors; a failure clears counts and the sum.
    always_comb begin
        n_vert_last  = w_eval_v ? w_v_last : r_vert_last;
        n_horiz_last = w_eval_h ? w_h_last : r_horiz_last;
        n_circ_last  = w_eval_c ? w_c_last : r_circ_last;
        if (w_fail) begin
            n_vert_cnt  = 4'd0;
            n_horiz_cnt = 4'd0;
            n_circ_cnt  = 4'd0;
            n_gyro_sum  = 32'sd0;
        end else begin
            n_vert_cnt  = w_eval_v ? w_v_cnt : r_vert_cnt;
            n_horiz_cnt = w_eval_h ? w_h_cnt : r_horiz_cnt;
            n_circ_cnt  = w_eval_c ? w_c_cnt : r_circ_cnt;
            n_gyro_sum  = w_eval_c ? w_c_sum : r_gyro_sum;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vert_thr     <= RST_VERT_THR;
            r_horiz_thr    <= RST_HORIZ_THR;
            r_circ_thr     <= RST_CIRC_THR;
            r_vert_goal    <= RST_GOAL;
            r_horiz_goal   <= RST_GOAL;
            r_circ_goal    <= RST_GOAL;
            r_idle_timeout <= RST_IDLE_TIMEOUT;
            r_shake_gap    <= RST_SHAKE_GAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VERT_THR:     r_vert_thr     <= i_cfg_data[15:0];
                REG_HORIZ_THR:    r_horiz_thr    <= i_cfg_data[15:0];
                REG_CIRC_THR:     r_circ_thr     <= i_cfg_data[30:0];
                REG_VERT_GOAL:    r_vert_goal    <= i_cfg_data[3:0];
                REG_HORIZ_GOAL:   r_horiz_goal   <= i_cfg_data[3:0];
                REG_CIRC_GOAL:    r_circ_goal    <= i_cfg_data[3:0];
                REG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[15:0];
                REG_SHAKE_GAP:    r_shake_gap    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_req;
        end
    end

    // Detector state and sequence step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_VERT;
            r_vert_cnt   <= 4'd0;
            r_horiz_cnt  <= 4'd0;
            r_circ_cnt   <= 4'd0;
            r_vert_last  <= 32'd0;
            r_horiz_last <= 32'd0;
            r_circ_last  <= 32'd0;
            r_gyro_sum   <= 32'sd0;
        end else if (w_advance) begin
            r_step       <= n_step;
            r_vert_cnt   <= n_vert_cnt;
            r_horiz_cnt  <= n_horiz_cnt;
            r_circ_cnt   <= n_circ_cnt;
            r_vert_last  <= n_vert_last;
            r_horiz_last <= n_horiz_last;
            r_circ_last  <= n_circ_last;
            r_gyro_sum   <= n_gyro_sum;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= r_in_valid;
        end
        if (w_advance) begin
            r_out.event_res  <= n_event;
            r_out.step_after <= n_step;
        end
    end

endmodule

`default_nettype wire

>>> rtl/mgsc_checker.sv
// Port-level assertions for the motion gesture sequence checker, with bind.
`default_nettype none

`include "motion_gesture_sequence_checker_assert.svh"

module mgsc_checker
    import mgsc_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire t_out_rsp   o_out_rsp
);

    // A stalled result request keeps its valid and its payload.
    `MGSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_rsp), "result request changed while stalled")

    // Only defined event codes appear.
    `MGSC_ASSERT_NOW(a_event_code, i_clk, i_rst_n, o_out_valid,
        o_out_rsp.event_res == EV_NONE || o_out_rsp.event_res == EV_STEP1 ||
        o_out_rsp.event_res == EV_STEP2 || o_out_rsp.event_res == EV_SUCCESS ||
        o_out_rsp.event_res == EV_FAIL, "undefined event code")

    // Success and failure both return the sequence to its first step.
    `MGSC_ASSERT_NOW(a_restart, i_clk, i_rst_n,
        o_out_valid && (o_out_rsp.event_res == EV_SUCCESS ||
        o_out_rsp.event_res == EV_FAIL),
        o_out_rsp.step_after == STEP_VERT, "sequence did not restart")

    // A finished first step leaves the horizontal step awaited.
    `MGSC_ASSERT_NOW(a_step1, i_clk, i_rst_n,
        o_out_valid && o_out_rsp.event_res == EV_STEP1,
        o_out_rsp.step_after == STEP_HORIZ, "step one did not advance")

    // A finished second step leaves the circle step awaited.
    `MGSC_ASSERT_NOW(a_step2, i_clk, i_rst_n,
        o_out_valid && o_out_rsp.event_res == EV_STEP2,
        o_out_rsp.step_after == STEP_CIRCLE, "step two did not advance")

endmodule

bind motion_gesture_sequence_checker mgsc_checker u_mgsc_checker (.*);

`default_nettype wire
